// ===== rtl/core/ssps_pkg.sv =====
// Package with the types, constants and codes shared by the step pulse sequencer files.
package ssps_pkg;

    localparam int SEGMENTS     = 20;
    localparam int COUNT_WIDTH  = 24;
    localparam int PERIOD_WIDTH = 16;
    localparam int SEG_AW       = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [SEG_AW-1:0] LAST_SEG = SEG_AW'(SEGMENTS - 1);

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,
        OP_START,
        OP_TICK
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_START_DATA,
        S_SEG_DATA,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  entry_index;
        logic [23:0] entry_pulse_mark;
        logic [15:0] entry_period;
        logic [23:0] move_steps;
        logic        move_direction;
        logic        arm_endstop;
        logic        endstop_level;
    } t_in_item;

    typedef struct packed {
        logic        step_out;
        logic        dir_out;
        logic        busy_res;
        logic        reload;
        logic [15:0] timer_period;
        logic        endstop_hit;
        logic        move_done;
        logic        hold_current;
    } t_out_item;

    typedef struct packed {
        t_op                     op;
        logic [SEG_AW-1:0]       index;
        logic [COUNT_WIDTH-1:0]  mark;
        logic [PERIOD_WIDTH-1:0] period;
        logic [COUNT_WIDTH-1:0]  steps;
        logic                    dir;
        logic                    arm;
        logic                    endstop;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0]  mark;
        logic [PERIOD_WIDTH-1:0] period;
    } t_seg_entry;

endpackage

// ===== rtl/core/ssps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ssps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ssps_front.sv =====
// Front end: accepts items, classifies them into commands and queues them for the back end.
module ssps_front import ssps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_in_item    i_item,
    input  logic        i_pop,
    output logic        busy,
    output t_queue_head o_head
);

    t_cmd              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              w_full;
    logic              w_push;
    logic              w_pop;
    t_cmd              w_cmd;

    assign w_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push = start && !w_full;
    assign w_pop  = i_pop && (r_count != '0);

    always_comb begin
        w_cmd.op      = OP_NOP;
        w_cmd.index   = SEG_AW'(i_item.entry_index);
        w_cmd.mark    = COUNT_WIDTH'(i_item.entry_pulse_mark);
        w_cmd.period  = PERIOD_WIDTH'(i_item.entry_period);
        w_cmd.steps   = COUNT_WIDTH'(i_item.move_steps);
        w_cmd.dir     = i_item.move_direction;
        w_cmd.arm     = i_item.arm_endstop;
        w_cmd.endstop = i_item.endstop_level;
        case (i_item.kind)
            KIND_LOAD: begin
                if (32'(i_item.entry_index) < 32'(SEGMENTS)) begin
                    w_cmd.op = OP_LOAD;
                end
            end
            KIND_START: w_cmd.op = OP_START;
            KIND_TICK:  w_cmd.op = OP_TICK;
            default:    w_cmd.op = OP_NOP;
        endcase
    end

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    assign busy         = w_full;
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_queue[r_rd_ptr];

endmodule

// ===== rtl/core/ssps_back.sv =====
// Back end: segment table, move state and the sequencer that carries out each command.
module ssps_back import ssps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    output logic        o_strobe,
    output t_out_item   o_result
);

    t_state                  r_state;
    t_state                  n_state;
    t_cmd                    r_cmd;
    t_cmd                    n_cmd;
    logic [COUNT_WIDTH-1:0]  r_counter;
    logic [COUNT_WIDTH-1:0]  n_counter;
    logic [COUNT_WIDTH-1:0]  r_target;
    logic [COUNT_WIDTH-1:0]  n_target;
    logic [SEG_AW-1:0]       r_seg;
    logic [SEG_AW-1:0]       n_seg;
    logic                    r_pin;
    logic                    n_pin;
    logic                    r_moving;
    logic                    n_moving;
    logic                    r_armed;
    logic                    n_armed;
    logic                    r_dir;
    logic                    n_dir;
    logic                    r_reload;
    logic                    n_reload;
    logic [PERIOD_WIDTH-1:0] r_period;
    logic [PERIOD_WIDTH-1:0] n_period;
    logic                    r_hit;
    logic                    n_hit;
    logic                    r_done;
    logic                    n_done;
    logic                    r_adv;
    logic                    n_adv;

    logic                    w_we;
    logic [SEG_AW-1:0]       w_raddr;
    t_seg_entry              w_wdata;
    t_seg_entry              w_rdata;
    logic                    w_mark_hit;

    ssps_ram #(
        .WIDTH ($bits(t_seg_entry)),
        .DEPTH (SEGMENTS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cmd.index),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_wdata.mark   = r_cmd.mark;
    assign w_wdata.period = r_cmd.period;
    assign w_mark_hit     = (r_counter == w_rdata.mark);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.op)
                    OP_START: n_state = r_moving ? S_REPORT : S_START_DATA;
                    OP_TICK: begin
                        if (!r_moving || (r_armed && r_cmd.endstop)) begin
                            n_state = S_REPORT;
                        end else begin
                            n_state = S_SEG_DATA;
                        end
                    end
                    default: n_state = S_REPORT;
                endcase
            end
            S_START_DATA: n_state = S_REPORT;
            S_SEG_DATA: begin
                if (!(w_mark_hit && (r_seg != LAST_SEG))) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath and control outputs.
    always_comb begin
        n_cmd     = r_cmd;
        n_counter = r_counter;
        n_target  = r_target;
        n_seg     = r_seg;
        n_pin     = r_pin;
        n_moving  = r_moving;
        n_armed   = r_armed;
        n_dir     = r_dir;
        n_reload  = r_reload;
        n_period  = r_period;
        n_hit     = r_hit;
        n_done    = r_done;
        n_adv     = 1'b0;
        w_we      = 1'b0;
        w_raddr   = r_seg;
        o_pop     = 1'b0;
        o_strobe  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop    = 1'b1;
                    n_cmd    = i_head.cmd;
                    n_reload = 1'b0;
                    n_period = '0;
                    n_hit    = 1'b0;
                    n_done   = 1'b0;
                end
            end
            S_EXEC: begin
                case (r_cmd.op)
                    OP_LOAD: w_we = 1'b1;
                    OP_START: begin
                        w_raddr = '0;
                        if (!r_moving) begin
                            n_target = r_cmd.steps;
                            n_dir    = r_cmd.dir;
                            n_armed  = r_cmd.arm;
                            n_seg    = '0;
                            n_moving = 1'b1;
                            n_reload = 1'b1;
                        end
                    end
                    OP_TICK: begin
                        if (r_moving && r_armed && r_cmd.endstop) begin
                            n_counter = '0;
                            n_target  = '0;
                            n_moving  = 1'b0;
                            n_pin     = 1'b0;
                            n_hit     = 1'b1;
                            n_done    = 1'b1;
                        end
                    end
                    default: n_cmd = r_cmd;
                endcase
            end
            S_START_DATA: n_period = w_rdata.period;
            S_SEG_DATA: begin
                if (r_adv) begin
                    n_period = w_rdata.period;
                end
                if (w_mark_hit) begin
                    if (r_seg != LAST_SEG) begin
                        n_seg    = r_seg + SEG_AW'(1);
                        w_raddr  = r_seg + SEG_AW'(1);
                        n_reload = 1'b1;
                        n_adv    = 1'b1;
                    end else begin
                        n_counter = '0;
                        n_target  = '0;
                        n_moving  = 1'b0;
                        n_pin     = 1'b0;
                        n_done    = 1'b1;
                        n_reload  = 1'b0;
                        n_period  = '0;
                    end
                end else if (!r_pin) begin
                    n_pin     = 1'b1;
                    n_counter = r_counter + COUNT_WIDTH'(1);
                end else begin
                    n_pin = 1'b0;
                    if (r_counter == r_target) begin
                        n_counter = '0;
                        n_target  = '0;
                        n_moving  = 1'b0;
                        n_done    = 1'b1;
                        n_reload  = 1'b0;
                        n_period  = '0;
                    end
                end
            end
            S_REPORT: o_strobe = 1'b1;
            default:  o_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_counter <= '0;
            r_target  <= '0;
            r_seg     <= '0;
            r_pin     <= 1'b0;
            r_moving  <= 1'b0;
            r_armed   <= 1'b0;
            r_dir     <= 1'b0;
            r_reload  <= 1'b0;
            r_period  <= '0;
            r_hit     <= 1'b0;
            r_done    <= 1'b0;
            r_adv     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_counter <= n_counter;
            r_target  <= n_target;
            r_seg     <= n_seg;
            r_pin     <= n_pin;
            r_moving  <= n_moving;
            r_armed   <= n_armed;
            r_dir     <= n_dir;
            r_reload  <= n_reload;
            r_period  <= n_period;
            r_hit     <= n_hit;
            r_done    <= n_done;
            r_adv     <= n_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_result.step_out     = r_pin;
    assign o_result.dir_out      = r_dir;
    assign o_result.busy_res     = r_moving;
    assign o_result.reload       = r_reload;
    assign o_result.timer_period = 16'(r_period);
    assign o_result.endstop_hit  = r_hit;
    assign o_result.move_done    = r_done;
    assign o_result.hold_current = !r_moving;

endmodule

// ===== rtl/core/segmented_step_pulse_sequencer.sv =====
// Top level of the segmented step pulse sequencer.
// Each transfer accepted on start (while busy is low) produces exactly one result, shown for a
// single cycle with o_strobe high; the receiver cannot stall, so results must be taken as they
// come. Items wait in a two-entry queue and are executed one at a time by the back-end
// sequencer through the idle, execute and report states; a start with no move running adds
// the start-data state, and a tick during a move that does not abort on the endstop adds the
// segment-data state, held for each segment it advances through, set by the registered read
// of the segment table. busy rises only while the queue is full.
module segmented_step_pulse_sequencer import ssps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_queue_head w_head;
    logic        w_pop;

    ssps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .i_pop   (w_pop),
        .busy    (busy),
        .o_head  (w_head)
    );

    ssps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
